// ===== rtl/sfd_pkg.sv =====
// ----------------------------------------------------------------------------
// sfd_pkg
// Shared types and constants of the sensor frame deframer: frame layout,
// event codes, arithmetic constants and the reply frame builder.
// ----------------------------------------------------------------------------
package sfd_pkg;

    // Frame delimiters.
    localparam logic [7:0] HDR0 = 8'hA0;
    localparam logic [7:0] HDR1 = 8'h0A;

    // Result event codes.
    localparam logic [2:0] EV_OK    = 3'd0;
    localparam logic [2:0] EV_CHK   = 3'd1;
    localparam logic [2:0] EV_START = 3'd2;
    localparam logic [2:0] EV_OVF   = 3'd3;
    localparam logic [2:0] EV_REPLY = 3'd4;

    // Node types and the crash code that trips the latch.
    localparam logic [7:0] TYPE_CAR  = 8'd1;
    localparam logic [7:0] TYPE_GUN  = 8'd2;
    localparam logic [7:0] CRASH_SET = 8'd1;

    // Frame layout (byte positions within a frame).
    localparam int FRAME_BYTES = 17;
    localparam int POS_HDR0    = 0;
    localparam int POS_HDR1    = 1;
    localparam int POS_SUM_LO  = 2;
    localparam int POS_ID      = 3;
    localparam int POS_TYPE    = 4;
    localparam int POS_SPD_HI  = 6;
    localparam int POS_SPD_LO  = 7;
    localparam int POS_LT_HI   = 8;
    localparam int POS_LT_LO   = 9;
    localparam int POS_SUM_HI  = 13;
    localparam int POS_CHK     = 14;
    localparam int POS_TRL0    = 15;

    // Field widths.
    localparam int SPEED_W = 19;
    localparam int LIGHT_W = 13;
    localparam int THR_W   = 13;

    // Speed scale, and divide by ten as a reciprocal multiply (exact for 16 bits).
    localparam logic [2:0]  SPEED_MUL   = 3'd6;
    localparam logic [15:0] DIV10_MUL   = 16'hCCCD;
    localparam int          DIV10_SHIFT = 19;

    // Reply frame.
    localparam int         REPLY_IDX_W    = 5;
    localparam logic [4:0] REPLY_LAST     = 5'd16;
    localparam logic [7:0] REPLY_BASE_SUM = 8'd31;

    // Configuration port.
    localparam int            PADDR_W       = 3;
    localparam int            PDATA_W       = 32;
    localparam logic          REG_LIGHT_THR = 1'b0;
    localparam logic [12:0]   THR_RESET     = 13'd30;

    // Outcome of one accepted beat, from the parser to the output stage.
    typedef struct packed {
        logic                 valid;
        logic [2:0]           event_res;
        logic [7:0]           node_id;
        logic [7:0]           node_type;
        logic [SPEED_W-1:0]   speed_value;
        logic [LIGHT_W-1:0]   light_value;
        logic [7:0]           crash_code;
        logic [7:0]           crash_total;
        logic                 bright;
        logic                 reply;
    } frame_res_t;

    // Persistent node status used while a reply is sent.
    typedef struct packed {
        logic [7:0] crash_total;
        logic       bright;
    } node_stat_t;

    // Byte idx of the reply frame.
    function automatic logic [7:0] reply_byte_at(input logic [REPLY_IDX_W-1:0] idx,
                                                 input logic [7:0] crash,
                                                 input logic bright);
        logic [7:0] val;
        val = 8'd0;
        case (idx) inside
            5'd0, 5'd16:       val = HDR0;
            5'd1, 5'd15:       val = HDR1;
            5'd2, 5'd3, 5'd4:  val = 8'd0;
            5'd5:              val = 8'd1;
            5'd6:              val = 8'd2;
            5'd7:              val = 8'd3;
            5'd8:              val = 8'd4;
            5'd9:              val = 8'd5;
            5'd10:             val = crash;
            5'd11:             val = 8'd7;
            5'd12:             val = {7'd0, bright};
            5'd13:             val = 8'd9;
            5'd14:             val = REPLY_BASE_SUM + crash + {7'd0, bright};
            default:           val = 8'd0;
        endcase
        return val;
    endfunction

endpackage

// ===== rtl/sfd_parse.sv =====
// ----------------------------------------------------------------------------
// sfd_parse
// Frame parser: tracks the byte position, captures the frame fields as they
// arrive, checks header, trailer and checksum, and keeps the node status.
// ----------------------------------------------------------------------------
module sfd_parse
    import sfd_pkg::*;
#(
    parameter int STORE_LIMIT = 20
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              beat_en,
    input  logic [7:0]        rx_byte,
    input  logic [THR_W-1:0]  light_threshold,
    output frame_res_t        res,
    output node_stat_t        stat
);

    localparam int FILL_W = $clog2(STORE_LIMIT + 1);

    // Control state.
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic              in_frame_reg, in_frame_next;
    logic [7:0]        sum_reg, sum_next;
    logic              crash_latch_reg, crash_latch_next;
    logic [7:0]        crash_count_reg, crash_count_next;
    logic              bright_reg, bright_next;

    // Captured frame bytes and precomputed fields.
    logic [7:0]         hdr0_reg;
    logic [7:0]         id_reg;
    logic [7:0]         type_reg;
    logic [7:0]         crash_code_reg;
    logic [SPEED_W-1:0] speed_reg;
    logic [7:0]         lt_hi_reg;
    logic [LIGHT_W-1:0] light_reg;
    logic [7:0]         chk_reg;
    logic [7:0]         trl0_reg;

    logic              wrap;
    logic [FILL_W-1:0] pos;
    logic [FILL_W-1:0] fill_cnt;
    logic              in_frame_base;
    logic [7:0]        sum_base;
    logic              sum_in_range;
    logic              chk_ok;
    logic [SPEED_W-1:0] speed_calc;
    logic [31:0]        light_prod;
    logic [LIGHT_W-1:0] light_calc;
    logic               bright_calc;

    // Position of this beat; a full store restarts at zero.
    assign wrap          = fill_reg >= FILL_W'(STORE_LIMIT);
    assign pos           = wrap ? '0 : fill_reg;
    assign in_frame_base = wrap ? 1'b0 : in_frame_reg;
    assign sum_base      = wrap ? 8'd0 : sum_reg;
    assign fill_cnt      = pos + FILL_W'(1);
    assign sum_in_range  = (pos >= FILL_W'(POS_SUM_LO)) && (pos <= FILL_W'(POS_SUM_HI));
    assign chk_ok        = sum_base == chk_reg;

    // Field arithmetic is done when the field's low byte arrives.
    assign speed_calc  = SPEED_W'({crash_code_reg, rx_byte}) * SPEED_W'(SPEED_MUL);
    assign light_prod  = 32'({lt_hi_reg, rx_byte}) * 32'(DIV10_MUL);
    assign light_calc  = light_prod[DIV10_SHIFT +: LIGHT_W];
    assign bright_calc = light_reg > light_threshold;

    // Next state and result of this beat.
    always_comb begin
        fill_next        = fill_cnt;
        in_frame_next    = in_frame_base;
        sum_next         = sum_in_range ? (sum_base + rx_byte) : sum_base;
        crash_latch_next = crash_latch_reg;
        crash_count_next = crash_count_reg;
        bright_next      = bright_reg;
        res              = '0;

        if (!in_frame_base) begin
            if (pos == FILL_W'(POS_HDR1)) begin
                if (hdr0_reg == HDR0 && rx_byte == HDR1) begin
                    in_frame_next = 1'b1;
                end else begin
                    fill_next     = '0;
                    in_frame_next = 1'b0;
                    sum_next      = 8'd0;
                    res.valid     = 1'b1;
                    res.event_res = EV_START;
                end
            end
        end else if (fill_cnt == FILL_W'(FRAME_BYTES) && trl0_reg == HDR1 &&
                     rx_byte == HDR0) begin
            // Complete frame.
            if (chk_ok) begin
                if (type_reg == TYPE_GUN) begin
                    bright_next = bright_calc;
                end else if (type_reg == TYPE_CAR && crash_code_reg == CRASH_SET &&
                             !crash_latch_reg) begin
                    crash_latch_next = 1'b1;
                    crash_count_next = crash_count_reg + 8'd1;
                end
            end
            fill_next       = '0;
            in_frame_next   = 1'b0;
            sum_next        = 8'd0;
            res.valid       = 1'b1;
            res.event_res   = chk_ok ? EV_OK : EV_CHK;
            res.node_id     = id_reg;
            res.node_type   = type_reg;
            res.speed_value = speed_reg;
            res.light_value = light_reg;
            res.crash_code  = crash_code_reg;
            res.reply       = type_reg != TYPE_GUN;
        end else if (fill_cnt >= FILL_W'(STORE_LIMIT)) begin
            fill_next     = '0;
            in_frame_next = 1'b0;
            sum_next      = 8'd0;
            res.valid     = 1'b1;
            res.event_res = EV_OVF;
        end

        res.valid       = res.valid & beat_en;
        res.crash_total = crash_count_next;
        res.bright      = bright_next;
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg        <= '0;
            in_frame_reg    <= 1'b0;
            sum_reg         <= 8'd0;
            crash_latch_reg <= 1'b0;
            crash_count_reg <= 8'd0;
            bright_reg      <= 1'b0;
        end else if (beat_en) begin
            fill_reg        <= fill_next;
            in_frame_reg    <= in_frame_next;
            sum_reg         <= sum_next;
            crash_latch_reg <= crash_latch_next;
            crash_count_reg <= crash_count_next;
            bright_reg      <= bright_next;
        end
    end

    // Byte capture by frame position.
    always_ff @(posedge aclk) begin
        if (beat_en) begin
            case (pos)
                FILL_W'(POS_HDR0):   hdr0_reg       <= rx_byte;
                FILL_W'(POS_ID):     id_reg         <= rx_byte;
                FILL_W'(POS_TYPE):   type_reg       <= rx_byte;
                FILL_W'(POS_SPD_HI): crash_code_reg <= rx_byte;
                FILL_W'(POS_SPD_LO): speed_reg      <= speed_calc;
                FILL_W'(POS_LT_HI):  lt_hi_reg      <= rx_byte;
                FILL_W'(POS_LT_LO):  light_reg      <= light_calc;
                FILL_W'(POS_CHK):    chk_reg        <= rx_byte;
                FILL_W'(POS_TRL0):   trl0_reg       <= rx_byte;
                default: ;
            endcase
        end
    end

    assign stat.crash_total = crash_count_reg;
    assign stat.bright      = bright_reg;

endmodule

// ===== rtl/sensor_frame_deframer_top.sv =====
// A result appears in the output register in the cycle after its byte is accepted.
// Throughput: one byte per cycle while the result side accepts; the parser handles every byte in a single pass.
// A frame that asks for a reply holds off input for the 17 reply beats that follow it.
// Reset: aresetn is synchronous and active low; it clears the parser, the node
// status, the result valid and the reply sequencer and sets the light threshold to 30.
// ----------------------------------------------------------------------------
// sensor_frame_deframer_top
// Byte stream deframer with an APB threshold register, a registered result
// channel and a reply sequencer that sends the 17-byte answer frame.
// ----------------------------------------------------------------------------
module sensor_frame_deframer_top
    import sfd_pkg::*;
#(
    parameter int STORE_LIMIT = 20
) (
    input  logic                aclk,
    input  logic                aresetn,
    // Configuration port.
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [PADDR_W-1:0]  paddr,
    input  logic [PDATA_W-1:0]  pwdata,
    output logic [PDATA_W-1:0]  prdata,
    output logic                pready,
    // Input channel.
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [7:0]          s_rx_byte,
    // Result channel.
    output logic                m_valid,
    input  logic                m_ready,
    output logic [2:0]          m_event_res,
    output logic [7:0]          m_node_id,
    output logic [7:0]          m_node_type,
    output logic [SPEED_W-1:0]  m_speed_value,
    output logic [LIGHT_W-1:0]  m_light_value,
    output logic [7:0]          m_crash_code,
    output logic [7:0]          m_crash_total,
    output logic                m_bright_out,
    output logic [7:0]          m_reply_byte,
    output logic                m_last
);

    logic [THR_W-1:0]       thr_reg;
    logic                   reg_sel;
    logic                   out_free;
    logic                   beat_en;
    logic                   burst_reg;
    logic [REPLY_IDX_W-1:0] reply_idx_reg;
    logic                   m_valid_reg;
    frame_res_t             res;
    node_stat_t             stat;

    // Configuration register.
    assign reg_sel = paddr[PADDR_W-1:2] == REG_LIGHT_THR;
    assign pready  = 1'b1;
    assign prdata  = reg_sel ? PDATA_W'(thr_reg) : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg <= THR_RESET;
        end else if (psel && penable && pwrite && reg_sel) begin
            thr_reg <= pwdata[THR_W-1:0];
        end
    end

    // Input is taken whenever the output register can be refilled and no reply is due.
    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = out_free && !burst_reg;
    assign beat_en  = s_valid && s_ready;

    sfd_parse #(
        .STORE_LIMIT (STORE_LIMIT)
    ) u_parse (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .beat_en         (beat_en),
        .rx_byte         (s_rx_byte),
        .light_threshold (thr_reg),
        .res             (res),
        .stat            (stat)
    );

    // Output valid and reply sequencer.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg   <= 1'b0;
            burst_reg     <= 1'b0;
            reply_idx_reg <= '0;
        end else if (out_free) begin
            if (burst_reg) begin
                m_valid_reg   <= 1'b1;
                reply_idx_reg <= reply_idx_reg + REPLY_IDX_W'(1);
                if (reply_idx_reg == REPLY_LAST) begin
                    burst_reg <= 1'b0;
                end
            end else begin
                m_valid_reg   <= res.valid;
                burst_reg     <= res.valid && res.reply;
                reply_idx_reg <= '0;
            end
        end
    end

    // Output payload.
    always_ff @(posedge aclk) begin
        if (out_free) begin
            if (burst_reg) begin
                m_event_res   <= EV_REPLY;
                m_node_id     <= 8'd0;
                m_node_type   <= 8'd0;
                m_speed_value <= '0;
                m_light_value <= '0;
                m_crash_code  <= 8'd0;
                m_crash_total <= stat.crash_total;
                m_bright_out  <= stat.bright;
                m_reply_byte  <= reply_byte_at(reply_idx_reg, stat.crash_total, stat.bright);
                m_last        <= reply_idx_reg == REPLY_LAST;
            end else begin
                m_event_res   <= res.event_res;
                m_node_id     <= res.node_id;
                m_node_type   <= res.node_type;
                m_speed_value <= res.speed_value;
                m_light_value <= res.light_value;
                m_crash_code  <= res.crash_code;
                m_crash_total <= res.crash_total;
                m_bright_out  <= res.bright;
                m_reply_byte  <= 8'd0;
                m_last        <= !res.reply;
            end
        end
    end

    assign m_valid = m_valid_reg;

endmodule

// ===== rtl/sfd_checker.sv =====
// ----------------------------------------------------------------------------
// sfd_checker
// Port-level checks of the deframer: back-pressure, stalled results, reply
// framing and single-beat error events.
// ----------------------------------------------------------------------------
module sfd_checker
    import sfd_pkg::*;
(
    input logic                aclk,
    input logic                aresetn,
    input logic                s_ready,
    input logic                m_valid,
    input logic                m_ready,
    input logic [2:0]          m_event_res,
    input logic [7:0]          m_reply_byte,
    input logic                m_last
);

    // A stalled result blocks new input beats.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |-> !s_ready)
        else $error("input accepted while a result is stalled");

    // A stalled result keeps its payload.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_event_res) && $stable(m_reply_byte))
        else $error("stalled result changed");

    // Reply byte is zero outside reply beats.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_event_res != EV_REPLY |-> m_reply_byte == 8'd0)
        else $error("reply byte set on a non-reply beat");

    // Start and overflow errors are single-beat results.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_event_res == EV_START || m_event_res == EV_OVF) |-> m_last)
        else $error("error event without last");

    // A frame result that is not last is followed at once by the reply header.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_last && (m_event_res == EV_OK || m_event_res == EV_CHK)
        |=> m_valid && m_event_res == EV_REPLY && m_reply_byte == HDR0)
        else $error("reply frame does not follow frame result");

endmodule

bind sensor_frame_deframer_top sfd_checker u_sfd_checker (.*);

// ===== tb/tb_sensor_frame_deframer_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sensor_frame_deframer_top
// Self-checking bench for the sensor frame deframer. Bytes go in over a
// valid/ready channel, and every byte is run through a behavioral copy of
// the parser, the checksum rule, the node status and the reply frame. Each
// result beat is checked field by field against the oldest expected beat.
// Directed frames cover header errors, the crash latch, brightness, unknown
// types, stray trailers, overflow, threshold settings and a long output stall.
// Random traffic follows, under threshold changes and random idling on both sides.
// ----------------------------------------------------------------------------
module tb_sensor_frame_deframer_top
    import sfd_pkg::*;
();

    localparam int CLK_HALF     = 1;
    localparam int STORE_LIMIT  = 20;
    localparam int RESET_CYCLES = 10;
    localparam int DRAIN_CYCLES = 8;
    localparam int HOLD_CYCLES  = 300;
    localparam int CYCLE_LIMIT  = 800000;
    localparam int MAX_REPORTS  = 40;
    localparam int RANDOM_BYTES = 28;

    // Light is reported in tenths of the raw reading.
    localparam int LIGHT_DIV = 10;
    localparam int THR_MAX   = 6553;

    // Layout of the data part of the reply frame.
    localparam int REPLY_DATA_POS    = 4;
    localparam int REPLY_DATA_LEN    = 10;
    localparam int REPLY_CRASH_SLOT  = 6;
    localparam int REPLY_BRIGHT_SLOT = 8;

    // One result beat as the block should present it.
    typedef struct {
        logic [2:0]         event_res;
        logic [7:0]         node_id;
        logic [7:0]         node_type;
        logic [SPEED_W-1:0] speed_value;
        logic [LIGHT_W-1:0] light_value;
        logic [7:0]         crash_code;
        logic [7:0]         crash_total;
        logic               bright;
        logic [7:0]         reply_byte;
        logic               last;
    } deframe_beat_t;

    logic               aclk = 1'b0;
    logic               aresetn;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;
    logic               s_valid;
    logic               s_ready;
    logic [7:0]         s_rx_byte;
    logic               m_valid;
    logic               m_ready;
    logic [2:0]         m_event_res;
    logic [7:0]         m_node_id;
    logic [7:0]         m_node_type;
    logic [SPEED_W-1:0] m_speed_value;
    logic [LIGHT_W-1:0] m_light_value;
    logic [7:0]         m_crash_code;
    logic [7:0]         m_crash_total;
    logic               m_bright_out;
    logic [7:0]         m_reply_byte;
    logic               m_last;

    // Parser and node status as the block should hold them.
    logic [7:0]       stored [STORE_LIMIT];
    int unsigned      stored_count;
    bit               hdr_seen;
    logic [7:0]       body_sum;
    bit               crash_seen;
    logic [7:0]       crash_tally;
    bit               bright_now;
    logic [THR_W-1:0] light_thr;

    deframe_beat_t    expected_beats [$];
    int               mismatch_count = 0;
    int               bytes_sent = 0;
    int               cycle_count = 0;
    bit               quiet_phase = 1'b0;
    bit               hold_req = 1'b0;

    sensor_frame_deframer_top #(
        .STORE_LIMIT(STORE_LIMIT)
    ) i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_rx_byte     (s_rx_byte),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_event_res   (m_event_res),
        .m_node_id     (m_node_id),
        .m_node_type   (m_node_type),
        .m_speed_value (m_speed_value),
        .m_light_value (m_light_value),
        .m_crash_code  (m_crash_code),
        .m_crash_total (m_crash_total),
        .m_bright_out  (m_bright_out),
        .m_reply_byte  (m_reply_byte),
        .m_last        (m_last)
    );

    always #(CLK_HALF) aclk = ~aclk;

    // Drop the partial frame and hunt for a header again.
    function automatic void clear_parser();
        stored_count = 0;
        hdr_seen     = 1'b0;
        body_sum     = 8'd0;
    endfunction

    // Node status fields are carried on every beat.
    function automatic deframe_beat_t status_beat(input logic [2:0] ev, input logic [7:0] id,
                                                  input logic [7:0] ty,
                                                  input logic [SPEED_W-1:0] spd,
                                                  input logic [LIGHT_W-1:0] lt,
                                                  input logic [7:0] cc, input logic [7:0] rb,
                                                  input bit last);
        deframe_beat_t bt;
        bt.event_res   = ev;
        bt.node_id     = id;
        bt.node_type   = ty;
        bt.speed_value = spd;
        bt.light_value = lt;
        bt.crash_code  = cc;
        bt.crash_total = crash_tally;
        bt.bright      = bright_now;
        bt.reply_byte  = rb;
        bt.last        = last;
        return bt;
    endfunction

    // Advance the parser by one accepted byte and queue the beats it causes.
    function automatic void predict_deframe(input logic [7:0] rx);
        int unsigned        pos;
        logic [15:0]        speed_raw;
        logic [15:0]        light_raw;
        logic [SPEED_W-1:0] spd;
        logic [LIGHT_W-1:0] lt;
        logic [7:0]         id;
        logic [7:0]         ty;
        logic [7:0]         cc;
        logic [7:0]         rb;
        logic [7:0]         answer_sum;
        logic [7:0]         answer [FRAME_BYTES];
        bit                 sum_ok;
        bit                 wants_reply;
        pos = stored_count;
        if (pos >= STORE_LIMIT) begin
            clear_parser();
            pos = 0;
        end
        stored[pos] = rx;
        if (pos >= POS_SUM_LO && pos <= POS_SUM_HI) begin
            body_sum = body_sum + rx;
        end
        stored_count = pos + 1;

        // Header hunt: the first two bytes decide once both are in.
        if (!hdr_seen) begin
            if (stored_count >= 2) begin
                if (stored[POS_HDR0] == HDR0 && stored[POS_HDR1] == HDR1) begin
                    hdr_seen = 1'b1;
                end else begin
                    clear_parser();
                    expected_beats.push_back(status_beat(EV_START, 8'd0, 8'd0, '0, '0,
                                                         8'd0, 8'd0, 1'b1));
                end
            end
            return;
        end

        // A frame ends only at its exact length with the trailer in place.
        if (stored_count == FRAME_BYTES && stored[POS_TRL0] == HDR1 &&
            stored[POS_TRL0 + 1] == HDR0) begin
            id          = stored[POS_ID];
            ty          = stored[POS_TYPE];
            cc          = stored[POS_SPD_HI];
            speed_raw   = {stored[POS_SPD_HI], stored[POS_SPD_LO]};
            light_raw   = {stored[POS_LT_HI], stored[POS_LT_LO]};
            spd         = SPEED_W'(32'(speed_raw) * 32'(SPEED_MUL));
            lt          = LIGHT_W'(32'(light_raw) / LIGHT_DIV);
            sum_ok      = (body_sum == stored[POS_CHK]);
            wants_reply = (ty != TYPE_GUN);
            if (sum_ok) begin
                if (ty == TYPE_GUN) begin
                    bright_now = (lt > light_thr);
                end else if (ty == TYPE_CAR && cc == CRASH_SET && !crash_seen) begin
                    crash_seen  = 1'b1;
                    crash_tally = crash_tally + 8'd1;
                end
            end
            clear_parser();
            expected_beats.push_back(status_beat(sum_ok ? EV_OK : EV_CHK, id, ty, spd, lt,
                                                 cc, 8'd0, !wants_reply));
            if (wants_reply) begin
                answer[POS_HDR0] = HDR0;
                answer[POS_HDR1] = HDR1;
                answer[2]        = 8'd0;
                answer[3]        = 8'd0;
                answer_sum       = 8'd0;
                for (int i = 0; i < REPLY_DATA_LEN; i++) begin
                    rb = 8'(i);
                    if (i == REPLY_CRASH_SLOT) begin
                        rb = crash_tally;
                    end else if (i == REPLY_BRIGHT_SLOT) begin
                        rb = {7'd0, bright_now};
                    end
                    answer[REPLY_DATA_POS + i] = rb;
                    answer_sum = answer_sum + rb;
                end
                answer[POS_CHK]      = answer_sum;
                answer[POS_TRL0]     = HDR1;
                answer[POS_TRL0 + 1] = HDR0;
                for (int i = 0; i < FRAME_BYTES; i++) begin
                    expected_beats.push_back(status_beat(EV_REPLY, 8'd0, 8'd0, '0, '0, 8'd0,
                                                         answer[i], i == FRAME_BYTES - 1));
                end
            end
        end else if (stored_count >= STORE_LIMIT) begin
            clear_parser();
            expected_beats.push_back(status_beat(EV_OVF, 8'd0, 8'd0, '0, '0, 8'd0, 8'd0,
                                                 1'b1));
        end
    endfunction

    // Offer one byte, with an occasional idle burst first. Entered and left
    // at a falling edge.
    task automatic send_byte(input logic [7:0] rx);
        if (!quiet_phase && $urandom_range(0, 5) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(negedge aclk);
        end
        s_valid   <= 1'b1;
        s_rx_byte <= rx;
        @(posedge aclk);
        while (!(s_valid && s_ready)) @(posedge aclk);
        predict_deframe(rx);
        bytes_sent++;
        @(negedge aclk);
    endtask

    // Build a frame around the given fields and send its first count bytes.
    task automatic send_frame(input logic [7:0] id, input logic [7:0] ty,
                              input logic [15:0] speed_raw, input logic [15:0] light_raw,
                              input bit sum_ok, input int count);
        logic [7:0] fb [FRAME_BYTES];
        logic [7:0] sum;
        foreach (fb[i]) fb[i] = 8'($urandom);
        fb[POS_HDR0]     = HDR0;
        fb[POS_HDR1]     = HDR1;
        fb[POS_ID]       = id;
        fb[POS_TYPE]     = ty;
        fb[POS_SPD_HI]   = speed_raw[15:8];
        fb[POS_SPD_LO]   = speed_raw[7:0];
        fb[POS_LT_HI]    = light_raw[15:8];
        fb[POS_LT_LO]    = light_raw[7:0];
        fb[POS_TRL0]     = HDR1;
        fb[POS_TRL0 + 1] = HDR0;
        sum = 8'd0;
        for (int i = POS_SUM_LO; i <= POS_SUM_HI; i++) sum = sum + fb[i];
        fb[POS_CHK] = sum_ok ? sum : sum + 8'($urandom_range(1, 255));
        for (int i = 0; i < count; i++) send_byte(fb[i]);
    endtask

    // Stop offering bytes and let every expected beat come out.
    task automatic wait_drained();
        s_valid <= 1'b0;
        while (expected_beats.size() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    // Register write: setup cycle, then access cycle.
    task automatic write_threshold(input logic [PDATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'(4 * REG_LIGHT_THR);
        pwdata  <= value;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        light_thr = value[THR_W-1:0];
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Bad first byte, bad second byte, and a reversed header.
    task automatic test_header_errors();
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(HDR0);
        send_byte(8'hFF);
        send_byte(HDR1);
        send_byte(HDR0);
    endtask

    // The first crash trips the latch; a second one is not counted.
    task automatic test_crash_latch();
        send_frame(8'h00, TYPE_CAR, {CRASH_SET, 8'h00}, 16'h0000, 1'b1, FRAME_BYTES);
        send_frame(8'hFF, TYPE_CAR, {CRASH_SET, 8'hFF}, 16'hFFFF, 1'b1, FRAME_BYTES);
    endtask

    // Full-scale gun reading sets the flag; a gun frame with a bad checksum
    // changes nothing and gets no reply.
    task automatic test_gun_brightness();
        send_frame(8'h5A, TYPE_GUN, 16'hFFFF, 16'hFFFF, 1'b1, FRAME_BYTES);
        send_frame(8'hA5, TYPE_GUN, 16'h0000, 16'h0000, 1'b0, FRAME_BYTES);
    endtask

    // An unknown type changes no state but is still answered.
    task automatic test_unknown_type();
        send_frame(8'h33, 8'hFF, 16'h0000, 16'h0000, 1'b1, FRAME_BYTES);
    endtask

    // A trailer at the wrong length is just stored; the parser runs into
    // the overflow instead.
    task automatic test_stray_trailer();
        send_byte(HDR0);
        send_byte(HDR1);
        send_byte(HDR1);
        send_byte(HDR0);
        repeat (FRAME_BYTES - 4) send_byte(8'h55);
        send_byte(HDR1);
        send_byte(HDR0);
        send_byte(8'h55);
    endtask

    // Threshold at both ends of its range, and a write with upper bits set.
    task automatic test_threshold_settings();
        wait_drained();
        write_threshold(32'd0);
        send_frame(8'h10, TYPE_GUN, 16'h0000, 16'(LIGHT_DIV), 1'b1, FRAME_BYTES);
        wait_drained();
        write_threshold(32'(THR_MAX));
        send_frame(8'h20, TYPE_GUN, 16'h0000, 16'hFFFF, 1'b1, FRAME_BYTES);
        wait_drained();
        // Only the low 13 bits land, leaving a threshold of 100.
        write_threshold(32'hFFFF_E064);
        send_frame(8'h30, TYPE_GUN, 16'h0000, 16'd1010, 1'b1, FRAME_BYTES);
    endtask

    // The result side stops for a long stretch while frames with replies
    // keep coming, so the block has to stall its input.
    task automatic test_output_backpressure();
        hold_req = 1'b1;
        repeat (3) begin
            send_frame(8'($urandom), TYPE_CAR, 16'($urandom), 16'($urandom), 1'b1,
                       FRAME_BYTES);
        end
    endtask

    // Mostly well-formed frames with random content, plus noise and cut
    // frames that end in start errors or overflows.
    task automatic test_random_traffic(input int byte_budget);
        int         first_byte;
        int         pick;
        logic [7:0] ty;
        logic [15:0] speed_raw;
        first_byte = bytes_sent;
        while (bytes_sent - first_byte < byte_budget) begin
            pick = $urandom_range(0, 9);
            ty   = (pick < 4) ? TYPE_CAR : (pick < 8) ? TYPE_GUN : 8'($urandom);
            speed_raw = ($urandom_range(0, 2) == 0) ? {CRASH_SET, 8'($urandom)}
                                                     : 16'($urandom);
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
                send_frame(8'($urandom), ty, speed_raw, 16'($urandom),
                           $urandom_range(0, 7) != 0, FRAME_BYTES);
            end else if (pick < 85) begin
                repeat ($urandom_range(1, 4)) begin
                    case ($urandom_range(0, 3))
                        0:       send_byte(HDR0);
                        1:       send_byte(HDR1);
                        default: send_byte(8'($urandom));
                    endcase
                end
            end else begin
                send_frame(8'($urandom), ty, speed_raw, 16'($urandom), 1'b1,
                           $urandom_range(2, FRAME_BYTES - 1));
            end
        end
    endtask

    // Result side: random stall bursts, or one long hold when asked.
    initial begin
        int stall_len;
        m_ready = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                hold_req = 1'b0;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                m_ready <= 1'b1;
            end else if (!quiet_phase && $urandom_range(0, 9) == 0) begin
                stall_len = $urandom_range(1, 16);
                m_ready <= 1'b0;
                repeat (stall_len) @(negedge aclk);
                m_ready <= 1'b1;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    task automatic check_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            if (mismatch_count < MAX_REPORTS) begin
                $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want,
                         got);
            end
            mismatch_count++;
        end
    endtask

    // Compare each accepted result beat with the oldest expected one.
    always @(posedge aclk) begin
        deframe_beat_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_beats.size() == 0) begin
                if (mismatch_count < MAX_REPORTS) begin
                    $display("%0t: result beat with none expected: expected none, actual event %0d",
                             $time, m_event_res);
                end
                mismatch_count++;
            end else begin
                want = expected_beats.pop_front();
                check_field("event_res", 32'(want.event_res), 32'(m_event_res));
                check_field("node_id", 32'(want.node_id), 32'(m_node_id));
                check_field("node_type", 32'(want.node_type), 32'(m_node_type));
                check_field("speed_value", 32'(want.speed_value), 32'(m_speed_value));
                check_field("light_value", 32'(want.light_value), 32'(m_light_value));
                check_field("crash_code", 32'(want.crash_code), 32'(m_crash_code));
                check_field("crash_total", 32'(want.crash_total), 32'(m_crash_total));
                check_field("bright_out", 32'(want.bright), 32'(m_bright_out));
                check_field("reply_byte", 32'(want.reply_byte), 32'(m_reply_byte));
                check_field("last", 32'(want.last), 32'(m_last));
            end
        end
    end

    // Watchdog.
    initial begin
        forever begin
            @(posedge aclk);
            cycle_count++;
            if (cycle_count >= CYCLE_LIMIT) begin
                $display("tb_sensor_frame_deframer_top: FAIL");
                $finish;
            end
        end
    end

    // Test sequence.
    initial begin
        aresetn   = 1'b0;
        psel      = 1'b0;
        penable   = 1'b0;
        pwrite    = 1'b0;
        paddr     = '0;
        pwdata    = '0;
        s_valid   = 1'b0;
        s_rx_byte = 8'd0;
        clear_parser();
        crash_seen  = 1'b0;
        crash_tally = 8'd0;
        bright_now  = 1'b0;
        light_thr   = THR_RESET;
        repeat (RESET_CYCLES) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        test_header_errors();
        test_crash_latch();
        test_gun_brightness();
        test_unknown_type();
        test_stray_trailer();
        test_threshold_settings();
        test_output_backpressure();

        wait_drained();
        write_threshold(32'($urandom_range(0, THR_MAX)));
        test_random_traffic(RANDOM_BYTES);
        wait_drained();
        write_threshold(32'($urandom_range(0, THR_MAX)));
        test_random_traffic(RANDOM_BYTES);
        wait_drained();
        write_threshold(32'($urandom_range(0, THR_MAX)));
        quiet_phase = 1'b1;
        test_random_traffic(RANDOM_BYTES);

        wait_drained();
        if (mismatch_count == 0 && expected_beats.size() == 0) begin
            $display("tb_sensor_frame_deframer_top: PASS");
        end else begin
            $display("tb_sensor_frame_deframer_top: FAIL");
        end
        $finish;
    end

endmodule
